### src/lis_pkg.sv
// Shared constants and types for the linear interpolation sequence generator.
`default_nettype none
package lis_pkg;

    localparam int DATA_W     = 32;             // one Q16.16 component
    localparam int NUM_COMP   = 3;
    localparam int FUNC_W     = 2;
    localparam int CNT_W      = 7;
    localparam int POS_W      = 6;
    localparam int CNT_MAX    = (1 << CNT_W) - 1;

    localparam int MAX_VALUES_DEF = 64;

    // divider: quotient bits retired per cycle, padded dividend width
    localparam int DIGIT_W    = 4;
    localparam int QUO_W      = ((DATA_W + 1 + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    localparam int DIV_STEPS  = QUO_W / DIGIT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int IN_TDATA_W  = ((2 * NUM_COMP * DATA_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((NUM_COMP * DATA_W + POS_W + 7) / 8) * 8;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_X    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_XY   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_XYZ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

    typedef struct packed {
        logic load;     // take a new magnitude, clear remainder
        logic shift;    // retire one digit of quotient
    } div_ctl_t;

endpackage
`default_nettype wire

### src/linear_interpolation_sequence.sv
// Top level: evenly spaced Q16.16 points between two 1..3 component end points.
// Sequence: for count >= 2, the magnitude state, then DIV_STEPS (9) divider steps
//   at 4 quotient bits each; m_tvalid rises once the run state starts issuing.
// Throughput: a new item is taken only in ST_IDLE, once the whole run has been issued;
//   the output run gives one point per cycle while m_tready holds high, else it stalls.
//   Error and count-one items skip the magnitude and divider states: one result each.
// Reset: aresetn, synchronous, active low; clears the sequencer and m_tvalid.
`default_nettype none
module linear_interpolation_sequence #(
    parameter int MAX_VALUES = lis_pkg::MAX_VALUES_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z, count, zero fill
    input  wire logic [lis_pkg::IN_TDATA_W-1:0]     s_tdata,
    // func
    input  wire logic [lis_pkg::FUNC_W-1:0]         s_tuser,
    // result items
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // val_x, val_y, val_z, position, zero fill
    output logic      [lis_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // error
    output logic                                    m_tuser,
    output logic                                    m_tlast
);
    import lis_pkg::*;

    // count saturates at MAX_VALUES; the count field caps it at 127 anyway
    localparam int N_CAP = (MAX_VALUES > CNT_MAX) ? CNT_MAX : MAX_VALUES;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(N_CAP);

    typedef enum logic [1:0] {ST_IDLE, ST_MAG, ST_DIV, ST_RUN} state_t;

    state_t                 state_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [CNT_W-1:0]       nm1_reg;        // n - 1: divisor and index of last point
    logic [CNT_W-1:0]       idx_reg;
    logic                   step_on_reg;    // off for error and single-point items
    logic                   err_reg;
    logic [DATA_W:0]        diff_reg [NUM_COMP];
    logic                   neg_reg  [NUM_COMP];
    logic [DATA_W-1:0]      acc_reg  [NUM_COMP];

    logic                   m_tvalid_reg;
    logic [DATA_W-1:0]      mval_reg [NUM_COMP];
    logic [POS_W-1:0]       mpos_reg;
    logic                   mlast_reg;
    logic                   merr_reg;

    // input decode
    logic [FUNC_W-1:0]      in_func;
    logic [CNT_W-1:0]       in_cnt;
    logic [CNT_W-1:0]       in_n;
    logic                   in_err;
    logic                   use_comp [NUM_COMP];
    logic [DATA_W-1:0]      from_m   [NUM_COMP];
    logic [DATA_W-1:0]      to_m     [NUM_COMP];
    logic [DATA_W:0]        diff_in  [NUM_COMP];

    // divider lanes
    div_ctl_t               div_ctl;
    logic [DATA_W:0]        mag      [NUM_COMP];
    logic [DATA_W-1:0]      quot     [NUM_COMP];

    logic                   accept;
    logic                   out_free;
    logic                   at_last;

    always_comb begin
        in_func = s_tuser;
        in_cnt  = s_tdata[2*NUM_COMP*DATA_W +: CNT_W];
        in_n    = (in_cnt > MAX_N) ? MAX_N : in_cnt;
        in_err  = (in_func == FUNC_RSVD) || (in_cnt == '0) ||
                  ((in_func == FUNC_XYZ) && (in_cnt == CNT_W'(1)));
        use_comp[0] = 1'b1;
        use_comp[1] = (in_func == FUNC_XY) || (in_func == FUNC_XYZ);
        use_comp[2] = (in_func == FUNC_XYZ);
        for (int c = 0; c < NUM_COMP; c++) begin
            from_m[c]  = use_comp[c] ? s_tdata[c*DATA_W +: DATA_W] : '0;
            to_m[c]    = use_comp[c] ? s_tdata[(NUM_COMP+c)*DATA_W +: DATA_W] : '0;
            diff_in[c] = {to_m[c][DATA_W-1], to_m[c]} - {from_m[c][DATA_W-1], from_m[c]};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign at_last  = (idx_reg == nm1_reg);

    // magnitudes go to the lanes; sign is applied when stepping
    always_comb begin
        div_ctl.load  = (state_reg == ST_MAG);
        div_ctl.shift = (state_reg == ST_DIV);
        for (int c = 0; c < NUM_COMP; c++) begin
            mag[c] = diff_reg[c][DATA_W] ? (DATA_W+1)'(-diff_reg[c]) : diff_reg[c];
        end
    end

    for (genvar g = 0; g < NUM_COMP; g++) begin : g_lane
        lis_div_lane u_lane (
            .aclk    (aclk),
            .ctl     (div_ctl),
            .mag     (mag[g]),
            .divisor (nm1_reg),
            .quot    (quot[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            div_cnt_reg  <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // output register: refilled from the run, else emptied when taken
            if ((state_reg == ST_RUN) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        idx_reg <= '0;
                        err_reg <= in_err;
                        for (int c = 0; c < NUM_COMP; c++) begin
                            diff_reg[c] <= diff_in[c];
                        end
                        if (in_err) begin
                            nm1_reg     <= '0;
                            step_on_reg <= 1'b0;
                            for (int c = 0; c < NUM_COMP; c++) begin
                                acc_reg[c] <= '0;
                            end
                            state_reg <= ST_RUN;
                        end else if (in_n == CNT_W'(1)) begin
                            // single point is the end point
                            nm1_reg     <= '0;
                            step_on_reg <= 1'b0;
                            for (int c = 0; c < NUM_COMP; c++) begin
                                acc_reg[c] <= to_m[c];
                            end
                            state_reg <= ST_RUN;
                        end else begin
                            nm1_reg     <= in_n - CNT_W'(1);
                            step_on_reg <= 1'b1;
                            for (int c = 0; c < NUM_COMP; c++) begin
                                acc_reg[c] <= from_m[c];
                            end
                            state_reg <= ST_MAG;
                        end
                    end
                end
                ST_MAG: begin
                    for (int c = 0; c < NUM_COMP; c++) begin
                        neg_reg[c] <= diff_reg[c][DATA_W];
                    end
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (out_free) begin
                        for (int c = 0; c < NUM_COMP; c++) begin
                            mval_reg[c] <= acc_reg[c];
                            if (step_on_reg) begin
                                acc_reg[c] <= neg_reg[c] ? acc_reg[c] - quot[c]
                                                         : acc_reg[c] + quot[c];
                            end
                        end
                        mpos_reg  <= idx_reg[POS_W-1:0];
                        mlast_reg <= at_last;
                        merr_reg  <= err_reg;
                        idx_reg   <= idx_reg + CNT_W'(1);
                        if (at_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W - NUM_COMP*DATA_W - POS_W)'(0), mpos_reg,
                       mval_reg[2], mval_reg[1], mval_reg[0]};
    assign m_tuser  = merr_reg;
    assign m_tlast  = mlast_reg;

    // an error item is one zero result that closes the run
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("error result not a single zero item");

    // a new item is only taken once the run is fully issued
    a_no_accept_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input accepted while a run is still open");

    // index never passes the last point of the run
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (idx_reg <= nm1_reg))
        else $error("run index beyond last point");

    // an accepted item holds off the input in the cycle after acceptance
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input ready straight after acceptance");

    // divider runs only for multi-point items
    a_div_step_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (step_on_reg && !err_reg))
        else $error("divider running for an error or single-point item");

endmodule
`default_nettype wire

### src/lis_div_lane.sv
// Digit-serial restoring divider lane: magnitude by a small divisor.
`default_nettype none
module lis_div_lane (
    input  wire logic                         aclk,
    input  wire lis_pkg::div_ctl_t            ctl,
    input  wire logic [lis_pkg::DATA_W:0]     mag,
    input  wire logic [lis_pkg::CNT_W-1:0]    divisor,
    output logic      [lis_pkg::DATA_W-1:0]   quot
);
    import lis_pkg::*;

    logic [QUO_W-1:0] sh_reg, sh_next;   // dividend in, quotient out
    logic [CNT_W-1:0] rem_reg, rem_next;

    always_comb begin
        logic [CNT_W:0] part;
        part     = '0;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        if (ctl.load) begin
            sh_next  = QUO_W'(mag);
            rem_next = '0;
        end else if (ctl.shift) begin
            for (int k = 0; k < DIGIT_W; k++) begin
                part    = {rem_next, sh_next[QUO_W-1]};
                sh_next = {sh_next[QUO_W-2:0], 1'b0};
                if (part >= {1'b0, divisor}) begin
                    part       = part - {1'b0, divisor};
                    sh_next[0] = 1'b1;
                end
                rem_next = part[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    // quotient never exceeds 2^32; the low word is enough for mod-2^32 stepping
    assign quot = sh_reg[DATA_W-1:0];

endmodule
`default_nettype wire
